/* rtl/ovbl_pkg.sv */
package ovbl_pkg;

    // Defaults for the top level's size parameters.
    localparam int DEF_MAX_OVERLAY_WIDTH  = 128;
    localparam int DEF_MAX_OVERLAY_HEIGHT = 128;
    localparam int DEF_MAX_FRAME_DIM      = 4096;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OVERLAY_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OVERLAY_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_X       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Y       = 3'd5;

    localparam logic [12:0] RST_FRAME_WIDTH    = 13'd640;
    localparam logic [12:0] RST_FRAME_HEIGHT   = 13'd480;
    localparam logic [7:0]  RST_OVERLAY_WIDTH  = 8'd128;
    localparam logic [7:0]  RST_OVERLAY_HEIGHT = 8'd128;
    localparam logic [11:0] RST_OFFSET_X       = 12'd0;
    localparam logic [11:0] RST_OFFSET_Y       = 12'd0;

    // Operation codes of an input beat.
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_BLEND = 1'b1;

    localparam logic [7:0] ALPHA_FULL = 8'd255;

    typedef struct packed {
        logic       operation;
        logic [11:0] coord_x;
        logic [11:0] coord_y;
        logic [7:0]  red_in;
        logic [7:0]  green_in;
        logic [7:0]  blue_in;
        logic [7:0]  alpha_in;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic       inside_window;
    } t_out_beat;

    // One stored overlay texel.
    typedef struct packed {
        logic [7:0] alpha;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } t_texel;

    // Load enables of the blend pipeline's registers.
    typedef struct packed {
        logic load_prod;
        logic load_out;
    } t_mix_ctl;

endpackage

/* rtl/ovbl_store.sv */
module ovbl_store #(
    parameter int DEPTH = ovbl_pkg::DEF_MAX_OVERLAY_WIDTH * ovbl_pkg::DEF_MAX_OVERLAY_HEIGHT,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic               i_clk,
    input  logic               i_we,
    input  logic [AW-1:0]      i_waddr,
    input  ovbl_pkg::t_texel   i_wdata,
    input  logic               i_re,
    input  logic [AW-1:0]      i_raddr,
    output ovbl_pkg::t_texel   o_rdata
);
    import ovbl_pkg::*;

    t_texel r_mem [DEPTH];
    t_texel r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/ovbl_window.sv */
module ovbl_window #(
    parameter int MAX_OVERLAY_WIDTH  = ovbl_pkg::DEF_MAX_OVERLAY_WIDTH,
    parameter int MAX_OVERLAY_HEIGHT = ovbl_pkg::DEF_MAX_OVERLAY_HEIGHT,
    parameter int MAX_FRAME_DIM      = ovbl_pkg::DEF_MAX_FRAME_DIM,
    parameter int AW = (MAX_OVERLAY_WIDTH * MAX_OVERLAY_HEIGHT > 1) ?
                       $clog2(MAX_OVERLAY_WIDTH * MAX_OVERLAY_HEIGHT) : 1
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [ovbl_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [ovbl_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  ovbl_pkg::t_in_beat                  i_beat,
    output logic                                o_inside,
    output logic                                o_load_ok,
    output logic [AW-1:0]                       o_addr
);
    import ovbl_pkg::*;

    localparam int FDW = $clog2(MAX_FRAME_DIM + 1);
    localparam int FW  = (FDW > 13) ? FDW : 13;
    localparam int OWW = $clog2(MAX_OVERLAY_WIDTH + 1);
    localparam int OHW = $clog2(MAX_OVERLAY_HEIGHT + 1);
    localparam int OMW = (OWW > OHW) ? OWW : OHW;
    localparam int SW  = (FW > OMW) ? FW : OMW;
    localparam int CXW = (MAX_OVERLAY_WIDTH > 1) ? $clog2(MAX_OVERLAY_WIDTH) : 1;
    localparam int CYW = (MAX_OVERLAY_HEIGHT > 1) ? $clog2(MAX_OVERLAY_HEIGHT) : 1;

    localparam logic [SW-1:0] FRAME_MAX = SW'(MAX_FRAME_DIM);
    localparam logic [SW-1:0] OVW_MAX   = SW'(MAX_OVERLAY_WIDTH);
    localparam logic [SW-1:0] OVH_MAX   = SW'(MAX_OVERLAY_HEIGHT);
    localparam logic [AW-1:0] ROW_PITCH = AW'(MAX_OVERLAY_WIDTH);

    logic [12:0] r_frame_w;
    logic [12:0] r_frame_h;
    logic [7:0]  r_ovl_w;
    logic [7:0]  r_ovl_h;
    logic [11:0] r_off_x;
    logic [11:0] r_off_y;

    logic [SW-1:0]  w_span_x;
    logic [SW-1:0]  w_span_y;
    logic [SW-1:0]  w_dx;
    logic [SW-1:0]  w_dy;
    logic           w_in_x;
    logic           w_in_y;
    logic [CXW-1:0] w_col;
    logic [CYW-1:0] w_row;

    // Extent of the window along one axis, clipped at the frame edge.
    function automatic logic [SW-1:0] span(input logic [SW-1:0] ov,
                                           input logic [SW-1:0] ov_max,
                                           input logic [SW-1:0] fr,
                                           input logic [SW-1:0] off);
        logic [SW-1:0] f;
        logic [SW-1:0] c;
        logic [SW-1:0] rem;
        begin
            f   = (fr < FRAME_MAX) ? fr : FRAME_MAX;
            c   = (ov < ov_max) ? ov : ov_max;
            c   = (c < f) ? c : f;
            rem = f - off;
            if (off >= f) begin
                span = '0;
            end else begin
                span = (rem < c) ? rem : c;
            end
        end
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_w <= RST_FRAME_WIDTH;
            r_frame_h <= RST_FRAME_HEIGHT;
            r_ovl_w   <= RST_OVERLAY_WIDTH;
            r_ovl_h   <= RST_OVERLAY_HEIGHT;
            r_off_x   <= RST_OFFSET_X;
            r_off_y   <= RST_OFFSET_Y;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_FRAME_WIDTH:    r_frame_w <= i_cfg_data;
                CFG_FRAME_HEIGHT:   r_frame_h <= i_cfg_data;
                CFG_OVERLAY_WIDTH:  r_ovl_w   <= i_cfg_data[7:0];
                CFG_OVERLAY_HEIGHT: r_ovl_h   <= i_cfg_data[7:0];
                CFG_OFFSET_X:       r_off_x   <= i_cfg_data[11:0];
                CFG_OFFSET_Y:       r_off_y   <= i_cfg_data[11:0];
                default: begin
                end
            endcase
        end
    end

    assign w_span_x = span(SW'(r_ovl_w), OVW_MAX, SW'(r_frame_w), SW'(r_off_x));
    assign w_span_y = span(SW'(r_ovl_h), OVH_MAX, SW'(r_frame_h), SW'(r_off_y));

    assign w_dx = SW'(i_beat.coord_x) - SW'(r_off_x);
    assign w_dy = SW'(i_beat.coord_y) - SW'(r_off_y);

    assign w_in_x = (i_beat.coord_x >= r_off_x) && (w_dx < w_span_x);
    assign w_in_y = (i_beat.coord_y >= r_off_y) && (w_dy < w_span_y);

    assign o_inside  = w_in_x && w_in_y;
    assign o_load_ok = (SW'(i_beat.coord_x) < OVW_MAX) && (SW'(i_beat.coord_y) < OVH_MAX);

    // Loads address the store by overlay coordinates, frame pixels by their
    // position relative to the window's corner. Both share one row multiply.
    always_comb begin
        if (i_beat.operation == OP_BLEND) begin
            w_col = w_dx[CXW-1:0];
            w_row = w_dy[CYW-1:0];
        end else begin
            w_col = i_beat.coord_x[CXW-1:0];
            w_row = i_beat.coord_y[CYW-1:0];
        end
    end

    assign o_addr = AW'(AW'(w_row) * ROW_PITCH) + AW'(w_col);

endmodule

/* rtl/ovbl_mix.sv */
module ovbl_mix (
    input  logic                i_clk,
    input  ovbl_pkg::t_mix_ctl  i_ctl,
    input  ovbl_pkg::t_texel    i_texel,
    input  logic [2:0][7:0]     i_frame,
    input  logic                i_inside,
    output ovbl_pkg::t_out_beat o_beat
);
    import ovbl_pkg::*;

    logic [2:0][7:0]  w_ovl;
    logic [7:0]       w_inv_a;
    logic [2:0][15:0] r_p_ovl;
    logic [2:0][15:0] r_p_frm;
    logic [2:0][7:0]  r_frame;
    logic             r_inside;
    logic [2:0][15:0] w_sum;
    t_out_beat        r_beat;

    assign w_ovl   = {i_texel.red, i_texel.green, i_texel.blue};
    assign w_inv_a = ALPHA_FULL - i_texel.alpha;

    // Product stage: both weighted terms of each channel.
    always_ff @(posedge i_clk) begin
        if (i_ctl.load_prod) begin
            for (int c = 0; c < 3; c++) begin
                r_p_ovl[c] <= 16'(w_ovl[c] * i_texel.alpha);
                r_p_frm[c] <= 16'(i_frame[c] * w_inv_a);
            end
            r_frame  <= i_frame;
            r_inside <= i_inside;
        end
    end

    // The two terms sum to at most 255 * 255, so 16 bits never overflow.
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_sum[c] = r_p_ovl[c] + r_p_frm[c];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_out) begin
            r_beat.red_out       <= r_inside ? w_sum[2][15:8] : r_frame[2];
            r_beat.green_out     <= r_inside ? w_sum[1][15:8] : r_frame[1];
            r_beat.blue_out      <= r_inside ? w_sum[0][15:8] : r_frame[0];
            r_beat.inside_window <= r_inside;
        end
    end

    assign o_beat = r_beat;

endmodule

/* rtl/rgba_overlay_alpha_blend_top.sv */
// A frame beat accepted at the input is registered in each pipeline stage in turn;
// load beats produce no output beat. Throughput: one beat per cycle unless the
// output stalls, loads and frame pixels mixed freely; the texel store has separate
// write and read ports, so a load never holds up a frame pixel.
// Reset (i_rst_n, synchronous, active low) empties the pipeline and restores the
// configuration registers; the texel store is not cleared.
module rgba_overlay_alpha_blend_top #(
    parameter int MAX_OVERLAY_WIDTH  = ovbl_pkg::DEF_MAX_OVERLAY_WIDTH,
    parameter int MAX_OVERLAY_HEIGHT = ovbl_pkg::DEF_MAX_OVERLAY_HEIGHT,
    parameter int MAX_FRAME_DIM      = ovbl_pkg::DEF_MAX_FRAME_DIM
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  ovbl_pkg::t_in_beat               i_in_data,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output ovbl_pkg::t_out_beat              o_out_data,
    input  logic                             i_cfg_we,
    input  logic [ovbl_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [ovbl_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import ovbl_pkg::*;

    localparam int DEPTH = MAX_OVERLAY_WIDTH * MAX_OVERLAY_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // Pipeline:
    //   stage 1 registers the incoming beat; the window logic decides whether a
    //           frame pixel is inside and forms the store address.
    //   stage 2 holds the texel read out of the store next to the frame pixel.
    //           A load writes the store as it leaves stage 1, so any frame
    //           pixel behind it reads the new texel. Loads leave the pipeline here.
    //   stage 3 holds the alpha-weighted products.
    //   stage 4 is the output register.
    // Every stage loads whenever it is empty or its content moves on, so the input
    // keeps accepting while a finished beat waits to be taken, until all stages fill.

    logic r_v1, r_v2, r_v3, r_v4;
    logic n_v1, n_v2, n_v3, n_v4;
    logic w_adv1, w_adv2, w_adv3, w_adv4;

    t_in_beat        r_s1;
    logic [2:0][7:0] r_frame2;
    logic            r_inside2;

    logic            w_inside;
    logic            w_load_ok;
    logic [AW-1:0]   w_addr;
    logic            w_we;
    t_texel          w_wtexel;
    t_texel          w_rtexel;
    t_mix_ctl        w_mix_ctl;

    assign w_adv4 = !r_v4 || !i_out_stall;
    assign w_adv3 = !r_v3 || w_adv4;
    assign w_adv2 = !r_v2 || w_adv3;
    assign w_adv1 = !r_v1 || w_adv2;

    always_comb begin
        n_v1 = w_adv1 ? i_in_valid : r_v1;
        n_v2 = w_adv2 ? (r_v1 && (r_s1.operation == OP_BLEND)) : r_v2;
        n_v3 = w_adv3 ? r_v2 : r_v3;
        n_v4 = w_adv4 ? r_v3 : r_v4;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= n_v1;
            r_v2 <= n_v2;
            r_v3 <= n_v3;
            r_v4 <= n_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv1) begin
            r_s1 <= i_in_data;
        end
        if (w_adv2) begin
            r_frame2  <= {r_s1.red_in, r_s1.green_in, r_s1.blue_in};
            r_inside2 <= w_inside;
        end
    end

    ovbl_window #(
        .MAX_OVERLAY_WIDTH  (MAX_OVERLAY_WIDTH),
        .MAX_OVERLAY_HEIGHT (MAX_OVERLAY_HEIGHT),
        .MAX_FRAME_DIM      (MAX_FRAME_DIM),
        .AW                 (AW)
    ) u_window (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_beat     (r_s1),
        .o_inside   (w_inside),
        .o_load_ok  (w_load_ok),
        .o_addr     (w_addr)
    );

    // Loads outside the store's bounds are dropped without a write.
    assign w_we = w_adv2 && r_v1 && (r_s1.operation == OP_LOAD) && w_load_ok;

    assign w_wtexel.red   = r_s1.red_in;
    assign w_wtexel.green = r_s1.green_in;
    assign w_wtexel.blue  = r_s1.blue_in;
    assign w_wtexel.alpha = r_s1.alpha_in;

    ovbl_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_addr),
        .i_wdata (w_wtexel),
        .i_re    (w_adv2),
        .i_raddr (w_addr),
        .o_rdata (w_rtexel)
    );

    assign w_mix_ctl.load_prod = w_adv3;
    assign w_mix_ctl.load_out  = w_adv4;

    ovbl_mix u_mix (
        .i_clk    (i_clk),
        .i_ctl    (w_mix_ctl),
        .i_texel  (w_rtexel),
        .i_frame  (r_frame2),
        .i_inside (r_inside2),
        .o_beat   (o_out_data)
    );

    assign o_in_stall  = !w_adv1;
    assign o_out_valid = r_v4;

endmodule

/* rtl/ovbl_checker.sv */
module ovbl_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_stall,
    input logic                i_out_valid,
    input logic                i_out_stall,
    input ovbl_pkg::t_out_beat i_out_data
);
    import ovbl_pkg::*;

    // A waiting output beat stays until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_stall |=> i_out_valid)
        else $error("output beat dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_stall |=> $stable(i_out_data))
        else $error("output beat changed while stalled");

    // The input only backs up when the pipeline is full behind a waiting beat.
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_stall |-> i_out_valid)
        else $error("input stalled with an empty output register");

    a_no_stall_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_stall |-> !i_in_stall)
        else $error("input stalled while the output drains");

endmodule

bind rgba_overlay_alpha_blend_top ovbl_checker u_ovbl_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_stall  (o_in_stall),
    .i_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .i_out_data  (o_out_data)
);
